// ===== rtl/channel_mode_command_fsm_assert.svh =====
// assertion macros for the channel mode controller
`ifndef CHANNEL_MODE_COMMAND_FSM_ASSERT_SVH
`define CHANNEL_MODE_COMMAND_FSM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CMFSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("channel mode controller: same-cycle check failed");

// next-cycle implication, checked outside reset
`define CMFSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("channel mode controller: next-cycle check failed");

`endif

// ===== rtl/cmfsm_pkg.sv =====
package cmfsm_pkg;

  // channel modes
  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_IDLE     = 2'd1,
    MODE_TRAN     = 2'd2,
    MODE_OUTPUT   = 2'd3
  } mode_t;

  // output status
  typedef enum logic [1:0] {
    STAT_CLOSED = 2'd0,
    STAT_CC     = 2'd1,
    STAT_CV     = 2'd2
  } status_t;

  // kind of transition in flight
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CC   = 2'd1,
    KIND_CV   = 2'd2,
    KIND_STOP = 2'd3
  } kind_t;

  // item actions
  typedef enum logic [1:0] {
    ACT_POST     = 2'd0,
    ACT_SERVICE  = 2'd1,
    ACT_WATCHDOG = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  // posted commands
  typedef enum logic [2:0] {
    CMD_OTHER = 3'd0,
    CMD_CC    = 3'd1,
    CMD_CV    = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_ENTER = 3'd4,
    CMD_LEAVE = 3'd5
  } cmd_t;

  // transition sequence requests
  typedef enum logic [2:0] {
    REQ_OFF_CC = 3'd0,
    REQ_CC_CC  = 3'd1,
    REQ_CC_OFF = 3'd2,
    REQ_OFF_CV = 3'd3,
    REQ_CV_CV  = 3'd4,
    REQ_CV_OFF = 3'd5
  } req_t;

  localparam logic [2:0] SEQ_FINISHED = 3'd2;
  localparam logic [1:0] OPT_AUTO     = 2'd2;

  // input beat
  typedef struct packed {
    logic [1:0] action;
    logic [3:0] channel;
    logic [2:0] command;
    logic [2:0] sequence_status;
    logic       schedule_lock;
    logic       unsafe_lock;
    logic [1:0] operate_type;
    logic       cali_board;
  } item_t;

  // result beat
  typedef struct packed {
    logic [3:0] out_channel;
    logic [1:0] mode;
    logic [1:0] output_status;
    logic       request_valid;
    logic [2:0] request_kind;
    logic       auto_calibrate;
    logic       still_pending;
    logic [1:0] operate_flag;
  } result_t;

  // per-channel state word
  typedef struct packed {
    mode_t      mode;
    status_t    status;
    logic       pending;
    kind_t      kind;
    logic [1:0] flag;
  } chan_state_t;

  localparam chan_state_t STATE_RESET = '{
    mode:    MODE_INACTIVE,
    status:  STAT_CLOSED,
    pending: 1'b0,
    kind:    KIND_NONE,
    flag:    2'd0
  };

endpackage

// ===== rtl/cmfsm_state_mem.sv =====
module cmfsm_state_mem
  import cmfsm_pkg::*;
#(
  parameter int CHANNELS = 16,
  parameter int IDX_W    = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output chan_state_t      rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  chan_state_t      wr_data
);

  chan_state_t         mem [CHANNELS];
  logic [CHANNELS-1:0] valid;
  chan_state_t         rd_word;
  logic                rd_valid;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // per-entry valid bits, cleared at once by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // an entry never written reads as its reset value
  assign rd_data = rd_valid ? rd_word : STATE_RESET;

endmodule

// ===== rtl/cmfsm_cmd_mem.sv =====
module cmfsm_cmd_mem
  import cmfsm_pkg::*;
#(
  parameter int CHANNELS = 16,
  parameter int IDX_W    = 4
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output cmd_t             rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [2:0]       wr_data
);

  logic [2:0] mem [CHANNELS];
  logic [2:0] rd_word;

  // latched command per channel, read on every accept and used only while its pending bit is set
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_data = cmd_t'(rd_word);

endmodule

// ===== rtl/cmfsm_step.sv =====
module cmfsm_step
  import cmfsm_pkg::*;
(
  input  item_t       item,
  input  logic [3:0]  chan,
  input  chan_state_t st,
  input  cmd_t        cmd,
  output chan_state_t ns,
  output result_t     res
);

  logic do_issue;
  req_t issue_kind;

  // one step of the channel controller
  always_comb begin
    ns         = st;
    do_issue   = 1'b0;
    issue_kind = REQ_OFF_CC;
    case (item.action)
      ACT_POST: begin
        ns.pending = 1'b1;
      end
      ACT_SERVICE: begin
        // pending command handling
        if (st.pending) begin
          if (item.schedule_lock) begin
            ns.pending = 1'b0;
          end else begin
            ns.pending = 1'b0;
            case (st.mode)
              MODE_IDLE: begin
                if (cmd inside {CMD_CC, CMD_CV}) begin
                  if (item.unsafe_lock) begin
                    ns.pending = 1'b1;
                  end else if (st.status == STAT_CLOSED) begin
                    do_issue   = 1'b1;
                    issue_kind = (cmd == CMD_CC) ? REQ_OFF_CC : REQ_OFF_CV;
                    ns.flag    = item.operate_type;
                    ns.kind    = (cmd == CMD_CC) ? KIND_CC : KIND_CV;
                    ns.mode    = MODE_TRAN;
                    ns.status  = (cmd == CMD_CC) ? STAT_CC : STAT_CV;
                  end
                end else if (cmd == CMD_LEAVE) begin
                  ns.mode = MODE_INACTIVE;
                  ns.flag = 2'd0;
                end
              end
              MODE_TRAN: begin
                if (cmd inside {CMD_STOP, CMD_LEAVE}) begin
                  if (st.status inside {STAT_CC, STAT_CV}) begin
                    do_issue   = 1'b1;
                    issue_kind = (st.status == STAT_CC) ? REQ_CC_OFF : REQ_CV_OFF;
                    ns.flag    = item.operate_type;
                    ns.kind    = KIND_STOP;
                  end
                  if (cmd == CMD_LEAVE) begin
                    ns.mode = MODE_INACTIVE;
                    ns.flag = 2'd0;
                  end
                  ns.status = STAT_CLOSED;
                end
              end
              MODE_OUTPUT: begin
                if (cmd == CMD_CC) begin
                  if (st.status == STAT_CC) begin
                    do_issue   = 1'b1;
                    issue_kind = REQ_CC_CC;
                    ns.flag    = item.operate_type;
                    ns.kind    = KIND_CC;
                    ns.mode    = MODE_TRAN;
                  end
                end else if (cmd == CMD_CV) begin
                  if (st.status inside {STAT_CLOSED, STAT_CV}) begin
                    do_issue   = 1'b1;
                    issue_kind = (st.status == STAT_CLOSED) ? REQ_OFF_CV : REQ_CV_CV;
                    ns.flag    = item.operate_type;
                    ns.status  = STAT_CV;
                    ns.kind    = KIND_CV;
                    ns.mode    = MODE_TRAN;
                  end
                end else if (cmd == CMD_STOP) begin
                  if (st.status inside {STAT_CC, STAT_CV}) begin
                    do_issue   = 1'b1;
                    issue_kind = (st.status == STAT_CC) ? REQ_CC_OFF : REQ_CV_OFF;
                    ns.flag    = item.operate_type;
                    ns.kind    = KIND_STOP;
                    ns.mode    = MODE_TRAN;
                  end
                  ns.status = STAT_CLOSED;
                end
              end
              default: begin
                if (cmd == CMD_ENTER) begin
                  ns.mode = MODE_IDLE;
                  ns.flag = item.operate_type;
                end
              end
            endcase
          end
        end
        // sequence status moves the transition on
        if (ns.mode == MODE_TRAN && item.sequence_status == SEQ_FINISHED) begin
          ns.mode = (ns.kind inside {KIND_CC, KIND_CV}) ? MODE_OUTPUT : MODE_IDLE;
        end
      end
      ACT_WATCHDOG: begin
        // forced stop of an outputting channel, unless cali_board is set
        if (!item.cali_board && st.mode == MODE_OUTPUT) begin
          ns.mode = MODE_TRAN;
          if (st.status inside {STAT_CC, STAT_CV}) begin
            do_issue   = 1'b1;
            issue_kind = (st.status == STAT_CC) ? REQ_CC_OFF : REQ_CV_OFF;
            ns.flag    = item.operate_type;
          end
          ns.kind   = KIND_STOP;
          ns.status = STAT_CLOSED;
        end
      end
      default: begin
        ns = st;
      end
    endcase
  end

  // result beat
  always_comb begin
    res.out_channel    = chan;
    res.mode           = ns.mode;
    res.output_status  = ns.status;
    res.request_valid  = do_issue;
    res.request_kind   = do_issue ? issue_kind : REQ_OFF_CC;
    res.auto_calibrate = do_issue && item.operate_type == OPT_AUTO
                         && issue_kind != REQ_CC_OFF && issue_kind != REQ_CV_OFF;
    res.still_pending  = ns.pending;
    res.operate_flag   = ns.flag;
  end

endmodule

// ===== rtl/channel_mode_command_fsm.sv =====
// per-channel mode controller: the result strobe follows busy, which is set at the accepting edge
// the result beat is registered at the write-back edge, the same edge that raises the strobe
// state memory read at the accepting edge, write-back while busy; no new item is taken until busy falls
// busy is high for the one cycle between accept and write-back; the result strobe lasts one cycle
// the receiver cannot stall, so only busy holds the input off
// reset clears control and the per-channel valid bits at once; no clearing pass is needed
module channel_mode_command_fsm
  import cmfsm_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    strobe,
  output result_t result
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [3:0]       wrap_lut [16];
  logic [3:0]       chan_in;
  logic [IDX_W-1:0] idx_in;
  logic             accept;

  item_t            item_q;
  logic [3:0]       chan_q;
  logic [IDX_W-1:0] idx_q;

  chan_state_t      st_rd;
  chan_state_t      st_next;
  cmd_t             cmd_rd;
  result_t          step_res;

  // channel wrap table, worked out at elaboration
  for (genvar i = 0; i < 16; i++) begin : g_wrap
    assign wrap_lut[i] = 4'(i % CHANNELS);
  end

  assign chan_in = wrap_lut[item.channel];
  assign idx_in  = IDX_W'(chan_in);
  assign accept  = start && !busy;

  // beat capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
      chan_q <= chan_in;
      idx_q  <= idx_in;
    end
  end

  // control: one busy cycle per beat, then the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      busy   <= accept;
      strobe <= busy;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (busy) begin
      result <= step_res;
    end
  end

  cmfsm_state_mem #(
    .CHANNELS(CHANNELS),
    .IDX_W   (IDX_W)
  ) u_state_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_addr(idx_in),
    .rd_data(st_rd),
    .wr_en  (busy),
    .wr_addr(idx_q),
    .wr_data(st_next)
  );

  cmfsm_cmd_mem #(
    .CHANNELS(CHANNELS),
    .IDX_W   (IDX_W)
  ) u_cmd_mem (
    .clk    (clk),
    .rd_en  (accept),
    .rd_addr(idx_in),
    .rd_data(cmd_rd),
    .wr_en  (busy && item_q.action == ACT_POST),
    .wr_addr(idx_q),
    .wr_data(item_q.command)
  );

  cmfsm_step u_step (
    .item(item_q),
    .chan(chan_q),
    .st  (st_rd),
    .cmd (cmd_rd),
    .ns  (st_next),
    .res (step_res)
  );

  // checks
`include "channel_mode_command_fsm_assert.svh"
  `CMFSM_ASSERT_NEXT(a_accept_busy, accept, busy)
  `CMFSM_ASSERT_NEXT(a_busy_strobe, busy, strobe && !busy)
  `CMFSM_ASSERT_NOW(a_no_req_quiet, strobe && !result.request_valid,
                    result.request_kind == REQ_OFF_CC && !result.auto_calibrate)
  `CMFSM_ASSERT_NOW(a_strobe_after_busy, strobe, $past(busy))

endmodule
